// File: sv/wpf_pkg.sv
// ----------------------------------------------------------------------------
// wpf_pkg - waypoint heading follower shared definitions
// Field widths, register codes, fixed-point constants and the CORDIC atan table.
// ----------------------------------------------------------------------------
package wpf_pkg;

	localparam int MAX_WAYPOINTS_DEF = 32;

	// payload widths
	localparam int POS_W   = 16;   // Q5.10 position
	localparam int HDG_W   = 15;   // Q2.12 heading
	localparam int SPD_W   = 15;   // Q3.12 speed magnitude
	localparam int ANG_W   = 16;   // Q3.12 signed turn command
	localparam int IDX_W   = 6;
	localparam int SLOT_W  = 5;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 15;
	localparam int HTOL_W  = 14;

	// internal datapath widths
	localparam int DELTA_W = POS_W + 1;   // waypoint minus pose
	localparam int CRD_W   = 34;          // CORDIC x/y, delta scaled by 2^14 plus gain
	localparam int Z_W     = 20;          // angle accumulator, 16 fractional bits
	localparam int DIFF_W  = 18;          // heading error, Q5.12
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W  = 4;

	localparam logic signed [Z_W-1:0]    HALF_PI_Q16 = 20'sd102944;
	localparam logic signed [DIFF_W-1:0] PI_Q12      = 18'sd12868;
	localparam logic signed [DIFF_W-1:0] TWO_PI_Q12  = 18'sd25736;

	// register reset values
	localparam logic [IDX_W-1:0]  WP_COUNT_RST   = 6'd0;
	localparam logic [SPD_W-1:0]  REACH_TOL_RST  = 15'd102;
	localparam logic [HTOL_W-1:0] HDG_TOL_RST    = 14'd410;
	localparam logic [SPD_W-1:0]  FWD_SPEED_RST  = 15'd1638;
	localparam logic [SPD_W-1:0]  TURN_RATE_RST  = 15'd1638;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WAYPOINT_COUNT    = 3'd0,
		REG_REACH_TOLERANCE   = 3'd1,
		REG_HEADING_TOLERANCE = 3'd2,
		REG_FORWARD_SPEED     = 3'd3,
		REG_TURN_RATE         = 3'd4
	} cfg_reg_t;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_READ  = 6'b000010,
		ST_PREP  = 6'b000100,
		ST_ITER  = 6'b001000,
		ST_EVAL  = 6'b010000,
		ST_DELIV = 6'b100000
	} wpf_state_t;

	// round(atan(2^-i) * 65536)
	function automatic logic [15:0] atan_q16(input logic [STEP_W-1:0] i);
		logic [15:0] v;
		unique case (i)
			4'd0:  v = 16'd51472;
			4'd1:  v = 16'd30385;
			4'd2:  v = 16'd16055;
			4'd3:  v = 16'd8150;
			4'd4:  v = 16'd4091;
			4'd5:  v = 16'd2047;
			4'd6:  v = 16'd1024;
			4'd7:  v = 16'd512;
			4'd8:  v = 16'd256;
			4'd9:  v = 16'd128;
			4'd10: v = 16'd64;
			4'd11: v = 16'd32;
			4'd12: v = 16'd16;
			4'd13: v = 16'd8;
			4'd14: v = 16'd4;
			4'd15: v = 16'd2;
			default: v = 16'd0;
		endcase
		return v;
	endfunction

endpackage

// File: sv/waypoint_heading_follower.sv
// ----------------------------------------------------------------------------
// waypoint_heading_follower - turn-then-drive waypoint steering
// Waypoint table plus a sequencer around one shared CORDIC vectoring stage.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): action=1 beats store (load_x, load_y)
//   at load_slot; action=0 beats are pose ticks steering toward the waypoint
//   at the current target index. Every input beat yields exactly one output
//   beat (out_valid/out_ready) with linear/angular commands, the target index
//   after the beat, and the reached / done flags.
//   Config channel (cfg_valid/cfg_ready) is always ready; write it only while
//   the block is idle. Index 0..4: count, reach tol, heading tol, speed, turn.
//   Steps: a pose tick goes from accept to out_valid through one delta
//   (the table is read at the accept edge), one pre-rotation, 16 CORDIC steps
//   through the single shift/add unit, one evaluate, one output write. Load
//   beats and ticks past the last waypoint go straight to the output write.
//   in_ready is high only while idle: no beat is taken until the last is written.
//   The output register holds a finished result while the receiver stalls;
//   the next beat is accepted and worked meanwhile, and waits to deliver.
//   Reset clears the target index and loads the register defaults; table
//   contents are undefined until loaded.
// ----------------------------------------------------------------------------
module waypoint_heading_follower #(
	parameter int MAX_WAYPOINTS = wpf_pkg::MAX_WAYPOINTS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// config write
	input  logic                                   cfg_valid,
	output logic                                   cfg_ready,
	input  logic [wpf_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [wpf_pkg::CFG_DATA_W-1:0]         cfg_data,
	// input items
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic                                   action,
	input  logic [wpf_pkg::SLOT_W-1:0]             load_slot,
	input  logic signed [wpf_pkg::POS_W-1:0]       load_x,
	input  logic signed [wpf_pkg::POS_W-1:0]       load_y,
	input  logic signed [wpf_pkg::POS_W-1:0]       pose_x,
	input  logic signed [wpf_pkg::POS_W-1:0]       pose_y,
	input  logic signed [wpf_pkg::HDG_W-1:0]       pose_heading,
	// results
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic [wpf_pkg::SPD_W-1:0]              linear_cmd,
	output logic signed [wpf_pkg::ANG_W-1:0]       angular_cmd,
	output logic [wpf_pkg::IDX_W-1:0]              waypoint_index,
	output logic                                   reached,
	output logic                                   done_res
);
	import wpf_pkg::*;

	localparam int AW = (MAX_WAYPOINTS > 2) ? $clog2(MAX_WAYPOINTS) : 1;

	// control state
	wpf_state_t        st_q;
	logic [STEP_W-1:0] it_q;
	logic [IDX_W-1:0]  target_index_q;
	logic              out_valid_q;

	// config registers
	logic [IDX_W-1:0]  wp_count_q;
	logic [SPD_W-1:0]  reach_tol_q;
	logic [HTOL_W-1:0] hdg_tol_q;
	logic [SPD_W-1:0]  fwd_speed_q;
	logic [SPD_W-1:0]  turn_rate_q;

	// waypoint table: y in upper half, x in lower half
	logic [2*POS_W-1:0] wp_mem [MAX_WAYPOINTS];
	logic [2*POS_W-1:0] rd_q;

	// datapath
	logic signed [POS_W-1:0]   pose_x_q, pose_y_q;
	logic signed [HDG_W-1:0]   hdg_q;
	logic signed [DELTA_W-1:0] dx_q, dy_q;
	logic signed [CRD_W-1:0]   x_q, y_q;
	logic signed [Z_W-1:0]     z_q;
	logic                      zero_q;

	logic [SPD_W-1:0]          res_lin_q;
	logic signed [ANG_W-1:0]   res_ang_q;
	logic                      res_reached_q;
	logic                      res_done_q;

	logic [SPD_W-1:0]          lin_q;
	logic signed [ANG_W-1:0]   ang_q;
	logic [IDX_W-1:0]          widx_q;
	logic                      reached_q;
	logic                      done_q;

	logic in_acc, out_free, deliver;
	logic done_now, slot_ok;
	logic mem_we, mem_re;
	logic [AW-1:0] wr_addr, rd_addr;

	assign in_ready  = (st_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign deliver   = (st_q == ST_DELIV) && out_free;

	// done when index reaches min(count, table depth)
	assign done_now = (target_index_q >= wp_count_q) ||
		(32'(target_index_q) >= 32'(MAX_WAYPOINTS));
	assign slot_ok  = 32'(load_slot) < 32'(MAX_WAYPOINTS);

	assign wr_addr = AW'(load_slot);
	assign rd_addr = AW'(target_index_q);
	assign mem_we  = in_acc && action && slot_ok;
	assign mem_re  = in_acc && !action;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			wp_mem[wr_addr] <= {load_y, load_x};
		end
		if (mem_re) begin
			rd_q <= wp_mem[rd_addr];
		end
	end

	// -------- delta and pre-rotation --------
	logic signed [POS_W-1:0]   wx, wy;
	logic signed [DELTA_W-1:0] dx_n, dy_n;
	logic signed [CRD_W-1:0]   x0, y0;

	assign wx   = rd_q[POS_W-1:0];
	assign wy   = rd_q[2*POS_W-1:POS_W];
	assign dx_n = DELTA_W'(wx) - DELTA_W'(pose_x_q);
	assign dy_n = DELTA_W'(wy) - DELTA_W'(pose_y_q);
	assign x0   = {{(CRD_W-DELTA_W-14){dx_q[DELTA_W-1]}}, dx_q, 14'b0};
	assign y0   = {{(CRD_W-DELTA_W-14){dy_q[DELTA_W-1]}}, dy_q, 14'b0};

	// -------- shared CORDIC step --------
	logic signed [CRD_W-1:0] xs, ys;
	logic signed [Z_W-1:0]   at;

	assign xs = x_q >>> it_q;
	assign ys = y_q >>> it_q;
	assign at = Z_W'(atan_q16(it_q));

	// -------- evaluate --------
	logic signed [Z_W:0]       zr;
	logic signed [ANG_W-1:0]   bearing;
	logic signed [DIFF_W-1:0]  diff_raw, diff;
	logic [DIFF_W-1:0]         adiff;
	logic [DELTA_W-1:0]        adx, ady;
	logic                      turn, reach_hit;

	assign zr       = (Z_W+1)'(z_q) + (Z_W+1)'(8);
	assign bearing  = zero_q ? '0 : ANG_W'(zr >>> 4);
	assign diff_raw = DIFF_W'(bearing) - DIFF_W'(hdg_q);

	// single wrap only
	always_comb begin
		priority if (diff_raw > PI_Q12) begin
			diff = diff_raw - TWO_PI_Q12;
		end else if (diff_raw < -PI_Q12) begin
			diff = diff_raw + TWO_PI_Q12;
		end else begin
			diff = diff_raw;
		end
	end

	assign adiff     = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
	assign turn      = adiff > DIFF_W'(hdg_tol_q);
	assign adx       = dx_q[DELTA_W-1] ? DELTA_W'(-dx_q) : DELTA_W'(dx_q);
	assign ady       = dy_q[DELTA_W-1] ? DELTA_W'(-dy_q) : DELTA_W'(dy_q);
	assign reach_hit = (adx < DELTA_W'(reach_tol_q)) && (ady < DELTA_W'(reach_tol_q));

	// -------- control --------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q           <= ST_IDLE;
			it_q           <= '0;
			target_index_q <= '0;
			out_valid_q    <= 1'b0;
			wp_count_q     <= WP_COUNT_RST;
			reach_tol_q    <= REACH_TOL_RST;
			hdg_tol_q      <= HDG_TOL_RST;
			fwd_speed_q    <= FWD_SPEED_RST;
			turn_rate_q    <= TURN_RATE_RST;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_WAYPOINT_COUNT:    wp_count_q  <= cfg_data[IDX_W-1:0];
					REG_REACH_TOLERANCE:   reach_tol_q <= cfg_data[SPD_W-1:0];
					REG_HEADING_TOLERANCE: hdg_tol_q   <= cfg_data[HTOL_W-1:0];
					REG_FORWARD_SPEED:     fwd_speed_q <= cfg_data[SPD_W-1:0];
					REG_TURN_RATE:         turn_rate_q <= cfg_data[SPD_W-1:0];
					default: ;
				endcase
			end

			if (deliver) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (st_q)
				ST_IDLE: begin
					if (in_acc) begin
						st_q <= (action || done_now) ? ST_DELIV : ST_READ;
					end
				end
				ST_READ: st_q <= ST_PREP;
				ST_PREP: begin
					st_q <= ST_ITER;
					it_q <= '0;
				end
				ST_ITER: begin
					it_q <= it_q + 1'b1;
					if (it_q == STEP_W'(CORDIC_STEPS-1)) begin
						st_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					st_q <= ST_DELIV;
					if (reach_hit) begin
						target_index_q <= target_index_q + 1'b1;
					end
				end
				ST_DELIV: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	// -------- datapath registers --------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pose_x_q      <= pose_x;
			pose_y_q      <= pose_y;
			hdg_q         <= pose_heading;
			res_lin_q     <= '0;
			res_ang_q     <= '0;
			res_reached_q <= 1'b0;
			res_done_q    <= !action && done_now;
		end

		if (st_q == ST_READ) begin
			dx_q <= dx_n;
			dy_q <= dy_n;
		end

		if (st_q == ST_PREP) begin
			zero_q <= (dx_q == '0) && (dy_q == '0);
			if (dx_q[DELTA_W-1]) begin
				if (!dy_q[DELTA_W-1]) begin
					x_q <= y0;
					y_q <= -x0;
					z_q <= HALF_PI_Q16;
				end else begin
					x_q <= -y0;
					y_q <= x0;
					z_q <= -HALF_PI_Q16;
				end
			end else begin
				x_q <= x0;
				y_q <= y0;
				z_q <= '0;
			end
		end

		if (st_q == ST_ITER) begin
			if (!y_q[CRD_W-1]) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end

		if (st_q == ST_EVAL) begin
			res_done_q    <= 1'b0;
			res_reached_q <= reach_hit;
			if (turn) begin
				res_lin_q <= '0;
				res_ang_q <= diff[DIFF_W-1] ? -ANG_W'(turn_rate_q) : ANG_W'(turn_rate_q);
			end else begin
				res_lin_q <= fwd_speed_q;
				res_ang_q <= '0;
			end
		end

		if (deliver) begin
			lin_q     <= res_lin_q;
			ang_q     <= res_ang_q;
			widx_q    <= target_index_q;
			reached_q <= res_reached_q;
			done_q    <= res_done_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign linear_cmd     = lin_q;
	assign angular_cmd    = ang_q;
	assign waypoint_index = widx_q;
	assign reached        = reached_q;
	assign done_res       = done_q;

`ifndef SYNTHESIS
	a_iter_to_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ITER && it_q == STEP_W'(CORDIC_STEPS-1)) |=> (st_q == ST_EVAL))
		else $error("CORDIC sequence did not end after its last step");

	a_reach_advances: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_EVAL && reach_hit) |=> (target_index_q == $past(target_index_q) + 1'b1))
		else $error("target index did not advance on reach");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(reached && done_res))
		else $error("reached and done set on one beat");

	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("input accepted while previous item still in flight");
`endif

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - waypoint heading follower testbench
// Loads waypoints, streams pose ticks and checks every output beat against a
// bit-exact steering predictor kept in a small scoreboard class. Directed
// corner cases first, then three random phases with different idle mixes.
// ----------------------------------------------------------------------------

import wpf_pkg::*;

localparam int WP_SLOTS     = MAX_WAYPOINTS_DEF;
localparam longint HDG_PI   = 12868;
localparam longint HDG_2PI  = 25736;
localparam longint QTR_TURN = 102944;   // pi/2 with 16 fractional bits

typedef struct packed {
	logic [SPD_W-1:0] linear;
	logic [ANG_W-1:0] angular;
	logic [IDX_W-1:0] wp_index;
	logic             reached;
	logic             done;
} steer_cmd_t;

class steer_scoreboard;
	logic [IDX_W-1:0]         wp_count;
	logic [SPD_W-1:0]         reach_tol;
	logic [HTOL_W-1:0]        hdg_tol;
	logic [SPD_W-1:0]         fwd_speed;
	logic [SPD_W-1:0]         turn_rate;
	logic signed [POS_W-1:0]  wp_x [WP_SLOTS];
	logic signed [POS_W-1:0]  wp_y [WP_SLOTS];
	bit                       written [WP_SLOTS];
	int unsigned              target;
	steer_cmd_t               cmd_expected [$];
	int                       errors;
	int                       n_load, n_drive, n_turn, n_done, n_reach, n_cfg;

	function void clear();
		wp_count  = WP_COUNT_RST;
		reach_tol = REACH_TOL_RST;
		hdg_tol   = HDG_TOL_RST;
		fwd_speed = FWD_SPEED_RST;
		turn_rate = TURN_RATE_RST;
		target    = 0;
		for (int i = 0; i < WP_SLOTS; i++) begin
			written[i] = 0;
			wp_x[i] = '0;
			wp_y[i] = '0;
		end
	endfunction

	function int unsigned eff_count();
		return (wp_count > WP_SLOTS) ? WP_SLOTS : wp_count;
	endfunction

	function void apply_write(cfg_reg_t r, logic [CFG_DATA_W-1:0] v);
		n_cfg++;
		case (r)
			REG_WAYPOINT_COUNT:    wp_count  = v[IDX_W-1:0];
			REG_REACH_TOLERANCE:   reach_tol = v[SPD_W-1:0];
			REG_HEADING_TOLERANCE: hdg_tol   = v[HTOL_W-1:0];
			REG_FORWARD_SPEED:     fwd_speed = v[SPD_W-1:0];
			REG_TURN_RATE:         turn_rate = v[SPD_W-1:0];
			default: ;
		endcase
	endfunction

	// CORDIC vectoring bearing, Q3.12 result
	function longint heading_to(longint dx, longint dy);
		longint atan_tbl [16];
		longint x, y, z, nx, xs, ys;
		atan_tbl = '{51472, 30385, 16055, 8150, 4091, 2047, 1024, 512,
			256, 128, 64, 32, 16, 8, 4, 2};
		if (dx == 0 && dy == 0)
			return 0;
		x = dx * 16384;
		y = dy * 16384;
		z = 0;
		if (x < 0) begin
			if (y >= 0) begin
				nx = y; y = -x; x = nx; z = QTR_TURN;
			end else begin
				nx = -y; y = x; x = nx; z = -QTR_TURN;
			end
		end
		for (int i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys; y = y - xs; z = z + atan_tbl[i];
			end else begin
				x = x - ys; y = y + xs; z = z - atan_tbl[i];
			end
		end
		return (z + 8) >>> 4;
	endfunction

	function void record_beat(bit act, logic [SLOT_W-1:0] slot,
			logic signed [POS_W-1:0] lx, logic signed [POS_W-1:0] ly,
			logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
			logic signed [HDG_W-1:0] hd);
		steer_cmd_t cmd;
		longint dx, dy, diff, adiff, ang;
		cmd = '0;
		if (act) begin
			n_load++;
			wp_x[slot] = lx;
			wp_y[slot] = ly;
			written[slot] = 1;
		end else if (target >= eff_count()) begin
			n_done++;
			cmd.done = 1'b1;
		end else begin
			dx = longint'(wp_x[target]) - longint'(px);
			dy = longint'(wp_y[target]) - longint'(py);
			diff = heading_to(dx, dy) - longint'(hd);
			if (diff > HDG_PI)
				diff = diff - HDG_2PI;
			else if (diff < -HDG_PI)
				diff = diff + HDG_2PI;
			adiff = (diff < 0) ? -diff : diff;
			if (adiff > longint'(hdg_tol)) begin
				n_turn++;
				ang = (diff > 0) ? longint'(turn_rate) : -longint'(turn_rate);
				cmd.angular = ANG_W'(ang);
			end else begin
				n_drive++;
				cmd.linear = fwd_speed;
			end
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			if (dx < longint'(reach_tol) && dy < longint'(reach_tol)) begin
				n_reach++;
				target = (target + 1) & 63;
				cmd.reached = 1'b1;
			end
		end
		cmd.wp_index = IDX_W'(target);
		cmd_expected = {cmd_expected, cmd};
	endfunction

	function void compare_field(string name, longint want, longint got);
		if (want != got) begin
			errors++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
		end
	endfunction

	function void check_result(steer_cmd_t got);
		steer_cmd_t want;
		if (cmd_expected.size() == 0) begin
			errors++;
			$display("%0t: unexpected beat, expected none actual lin %0d ang %0d idx %0d",
				$time, got.linear, $signed(got.angular), got.wp_index);
			return;
		end
		want = cmd_expected.pop_front();
		compare_field("linear_cmd", longint'(want.linear), longint'(got.linear));
		compare_field("angular_cmd", longint'($signed(want.angular)),
			longint'($signed(got.angular)));
		compare_field("waypoint_index", longint'(want.wp_index), longint'(got.wp_index));
		compare_field("reached", longint'(want.reached), longint'(got.reached));
		compare_field("done_res", longint'(want.done), longint'(got.done));
	endfunction
endclass

module tb_top;

	localparam int CYCLE_LIMIT = 600000;
	localparam int SETTLE      = 24;    // extra settle time after each drain
	localparam int REACH_PCT   = 3;

	logic                      clk;
	logic                      arst_n       = 1'b0;
	logic                      cfg_valid    = 1'b0;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index    = '0;
	logic [CFG_DATA_W-1:0]     cfg_data     = '0;
	logic                      in_valid     = 1'b0;
	logic                      in_ready;
	logic                      action       = 1'b0;
	logic [SLOT_W-1:0]         load_slot    = '0;
	logic signed [POS_W-1:0]   load_x       = '0;
	logic signed [POS_W-1:0]   load_y       = '0;
	logic signed [POS_W-1:0]   pose_x       = '0;
	logic signed [POS_W-1:0]   pose_y       = '0;
	logic signed [HDG_W-1:0]   pose_heading = '0;
	logic                      out_valid;
	logic                      out_ready    = 1'b0;
	logic [SPD_W-1:0]          linear_cmd;
	logic signed [ANG_W-1:0]   angular_cmd;
	logic [IDX_W-1:0]          waypoint_index;
	logic                      reached;
	logic                      done_res;

	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int cycle_count   = 0;
	steer_scoreboard sb = new;

	waypoint_heading_follower dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.action(action), .load_slot(load_slot),
		.load_x(load_x), .load_y(load_y),
		.pose_x(pose_x), .pose_y(pose_y), .pose_heading(pose_heading),
		.out_valid(out_valid), .out_ready(out_ready),
		.linear_cmd(linear_cmd), .angular_cmd(angular_cmd),
		.waypoint_index(waypoint_index), .reached(reached), .done_res(done_res)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	always @(negedge clk) out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(steer_cmd_t'({linear_cmd, angular_cmd, waypoint_index,
				reached, done_res}));
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("timeout after %0d cycles, %0d beats outstanding",
			CYCLE_LIMIT, sb.cmd_expected.size());
		$display("status: fail");
		$finish;
	end

	function automatic logic signed [POS_W-1:0] rand_pos();
		int unsigned pick;
		pick = $urandom_range(0, 19);
		case (pick)
			0: return 16'sh8000;
			1: return 16'sh7FFF;
			default: return POS_W'($urandom_range(0, 65535));
		endcase
	endfunction

	function automatic logic signed [HDG_W-1:0] clamp_hdg(longint v);
		if (v > HDG_PI) return HDG_W'(HDG_PI);
		if (v < -HDG_PI) return HDG_W'(-HDG_PI);
		return HDG_W'(v);
	endfunction

	function automatic logic signed [POS_W-1:0] clamp_pos(longint v);
		if (v > 32767) return 16'sh7FFF;
		if (v < -32768) return 16'sh8000;
		return POS_W'(v);
	endfunction

	function automatic logic signed [HDG_W-1:0] rand_hdg();
		int unsigned pick;
		longint v;
		pick = $urandom_range(0, 19);
		v = $urandom_range(0, 25736);
		case (pick)
			0: return clamp_hdg(-HDG_PI);
			1: return clamp_hdg(HDG_PI);
			default: return clamp_hdg(v - HDG_PI);
		endcase
	endfunction

	function automatic int unsigned reg_value(cfg_reg_t r);
		int unsigned top;
		int unsigned pick;
		top = (r == REG_HEADING_TOLERANCE) ? int'(HDG_PI) : 32767;
		pick = $urandom_range(0, 3);
		case (pick)
			0: return 0;
			1: return top;
			default: return $urandom_range(0, top);
		endcase
	endfunction

	task automatic write_reg(cfg_reg_t r, int unsigned value);
		@(negedge clk);
		cfg_index <= r;
		cfg_data  <= CFG_DATA_W'(value);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		sb.apply_write(r, CFG_DATA_W'(value));
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_item(bit act, logic [SLOT_W-1:0] slot,
			logic signed [POS_W-1:0] lx, logic signed [POS_W-1:0] ly,
			logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
			logic signed [HDG_W-1:0] hd);
		@(negedge clk);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		action       <= act;
		load_slot    <= slot;
		load_x       <= lx;
		load_y       <= ly;
		pose_x       <= px;
		pose_y       <= py;
		pose_heading <= hd;
		in_valid     <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sb.record_beat(act, slot, lx, ly, px, py, hd);
	endtask

	// unused fields of each beat carry noise
	task automatic load_wp(int unsigned slot, logic signed [POS_W-1:0] x,
			logic signed [POS_W-1:0] y);
		send_item(1'b1, SLOT_W'(slot), x, y, rand_pos(), rand_pos(), rand_hdg());
	endtask

	task automatic tick(logic signed [POS_W-1:0] px, logic signed [POS_W-1:0] py,
			logic signed [HDG_W-1:0] hd);
		send_item(1'b0, SLOT_W'($urandom_range(0, 31)), rand_pos(), rand_pos(), px, py, hd);
	endtask

	// hold the sender off until every beat is back, then let the block settle
	task automatic drain(int extra);
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.cmd_expected.size() != 0) @(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic random_tick();
		int unsigned t, mode;
		longint wx, wy, px, py, tol, htol, off;
		bit attempt;
		logic signed [HDG_W-1:0] hd;
		t = sb.target;
		if (t >= sb.eff_count()) begin
			tick(rand_pos(), rand_pos(), rand_hdg());
			return;
		end
		// never steer toward a slot that was not loaded
		if (!sb.written[t]) begin
			load_wp(t, rand_pos(), rand_pos());
			return;
		end
		wx = sb.wp_x[t];
		wy = sb.wp_y[t];
		tol = sb.reach_tol;
		htol = sb.hdg_tol;
		mode = $urandom_range(0, 99);
		attempt = (mode < REACH_PCT) && (tol > 0);
		if (attempt) begin
			off = $urandom_range(0, 2 * (tol - 1));
			px = longint'(clamp_pos(wx + off - (tol - 1)));
			off = $urandom_range(0, 2 * (tol - 1));
			py = longint'(clamp_pos(wy + off - (tol - 1)));
		end else if (mode < 45) begin
			off = $urandom_range(0, 4 * tol + 128);
			px = longint'(clamp_pos(wx + off - (2 * tol + 64)));
			off = $urandom_range(0, 4 * tol + 128);
			py = longint'(clamp_pos(wy + off - (2 * tol + 64)));
		end else begin
			px = rand_pos();
			py = rand_pos();
		end
		// keep advances rare so the path lasts the whole run
		if (!attempt && (wx - px < tol) && (px - wx < tol) && (wy - py < tol) && (py - wy < tol))
			px = (wx >= 0) ? -32768 : 32767;
		if ($urandom_range(0, 1)) begin
			off = $urandom_range(0, 2 * htol + 6);
			hd = clamp_hdg(sb.heading_to(wx - px, wy - py) - (off - (htol + 3)));
		end else begin
			hd = rand_hdg();
		end
		tick(clamp_pos(px), clamp_pos(py), hd);
	endtask

	task automatic random_load();
		int unsigned slot;
		if ($urandom_range(0, 99) < 60)
			slot = (sb.target + $urandom_range(0, 4)) % WP_SLOTS;
		else
			slot = $urandom_range(0, WP_SLOTS - 1);
		load_wp(slot, rand_pos(), rand_pos());
	endtask

	task automatic run_phase(int s_pct, int r_pct, int n_items, int retune_pct);
		int items, len, pick;
		int unsigned cnt;
		cfg_reg_t r;
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		items = 0;
		while (items < n_items) begin
			drain(SETTLE);
			pick = $urandom_range(0, 99);
			if (pick < 80)
				cnt = sb.target + $urandom_range(1, 5);
			else if (pick < 90)
				cnt = 63;
			else
				cnt = $urandom_range(0, 32);
			if (cnt > 63) cnt = 63;
			write_reg(REG_WAYPOINT_COUNT, cnt);
			if ($urandom_range(0, 99) < retune_pct) begin
				r = cfg_reg_t'($urandom_range(REG_REACH_TOLERANCE, REG_TURN_RATE));
				write_reg(r, reg_value(r));
			end
			len = $urandom_range(15, 60);
			for (int k = 0; k < len && items < n_items; k++) begin
				if ($urandom_range(0, 99) < 30)
					random_load();
				else
					random_tick();
				items++;
			end
		end
	endtask

	initial begin
		longint b;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		sb.clear();
		recv_idle_pct = 50;

		// directed: done with an empty path, then the corner cases
		tick(16'sd0, 16'sd0, 15'sd0);
		drain(SETTLE);
		write_reg(REG_WAYPOINT_COUNT, 4);
		write_reg(REG_REACH_TOLERANCE, 102);
		write_reg(REG_HEADING_TOLERANCE, 410);
		write_reg(REG_FORWARD_SPEED, 1638);
		write_reg(REG_TURN_RATE, 1638);
		load_wp(0, 16'sd1024, 16'sd0);
		load_wp(1, 16'sh8000, 16'sh7FFF);
		load_wp(2, 16'sh7FFF, 16'sh8000);
		load_wp(3, -16'sd1024, 16'sd0);
		load_wp(31, 16'sh8000, 16'sh8000);
		tick(16'sd0, 16'sd0, 15'sd0);
		tick(16'sd0, 16'sd0, clamp_hdg(HDG_PI));
		tick(16'sd0, 16'sd0, clamp_hdg(-HDG_PI));
		// heading error right at the tolerance drives, one past turns
		b = sb.heading_to(1024, 500);
		tick(16'sd0, -16'sd500, clamp_hdg(b - 410));
		tick(16'sd0, -16'sd500, clamp_hdg(b - 411));
		tick(16'sd0, -16'sd500, clamp_hdg(b + 410));
		// distance equal to the reach tolerance does not reach, one less does
		tick(16'sd922, 16'sd0, 15'sd0);
		tick(16'sd923, 16'sd101, 15'sd0);
		// largest deltas both ways, each followed by a zero delta that reaches
		tick(16'sh7FFF, 16'sh8000, clamp_hdg(-HDG_PI));
		tick(16'sh8000, 16'sh7FFF, 15'sd0);
		tick(16'sh8000, 16'sh7FFF, clamp_hdg(HDG_PI));
		tick(16'sh7FFF, 16'sh8000, 15'sd5);
		// bearing near +/-pi needs the wrap
		tick(16'sd0, 16'sd0, clamp_hdg(-HDG_PI));
		tick(16'sd0, 16'sd0, clamp_hdg(HDG_PI));
		tick(16'sd0, 16'sd5, clamp_hdg(HDG_PI));
		tick(-16'sd1024, 16'sd0, clamp_hdg(-HDG_PI));
		tick(16'sd100, 16'sd100, 15'sd100);
		// shrinking the count leaves the index alone
		drain(SETTLE);
		write_reg(REG_WAYPOINT_COUNT, 2);
		tick(16'sd0, 16'sd0, 15'sd0);

		drain(SETTLE);
		write_reg(REG_REACH_TOLERANCE, 102);
		write_reg(REG_HEADING_TOLERANCE, 410);
		write_reg(REG_FORWARD_SPEED, 1638);
		write_reg(REG_TURN_RATE, 1638);
		run_phase(15, 79, 500, 30);

		drain(SETTLE);
		write_reg(REG_REACH_TOLERANCE, 32767);
		write_reg(REG_HEADING_TOLERANCE, 32'(HDG_PI));
		write_reg(REG_FORWARD_SPEED, 32767);
		write_reg(REG_TURN_RATE, 32767);
		run_phase(79, 15, 500, 30);

		drain(SETTLE);
		write_reg(REG_REACH_TOLERANCE, 0);
		write_reg(REG_HEADING_TOLERANCE, 0);
		write_reg(REG_FORWARD_SPEED, 0);
		write_reg(REG_TURN_RATE, 1);
		run_phase(0, 0, 500, 60);

		drain(SETTLE + 10);
		if (sb.cmd_expected.size() != 0) begin
			sb.errors++;
			$display("%0t: %0d expected beats never arrived", $time, sb.cmd_expected.size());
		end
		$display("covered %0d loads and %0d pose ticks: %0d drive, %0d turn, %0d done",
			sb.n_load, sb.n_drive + sb.n_turn + sb.n_done, sb.n_drive, sb.n_turn, sb.n_done);
		$display("%0d waypoints reached, final index %0d, %0d register writes, %0d errors",
			sb.n_reach, sb.target, sb.n_cfg, sb.errors);
		if (sb.errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
